@@ sv/ilist_pkg.sv @@
// Shared types and constants for the indexed list engine.
// No dependencies; used by ilist_ctrl, ilist_dpath and indexed_list_engine.
package ilist_pkg;

  // Default number of list cells
  localparam int CAPACITY_DEF = 16;

  // Operation codes carried in the kind field
  typedef enum logic [2:0] {
    KIND_READ   = 3'd0,
    KIND_HEAD   = 3'd1,
    KIND_TAIL   = 3'd2,
    KIND_AT     = 3'd3,
    KIND_DELETE = 3'd4
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What the decoded operation turns into
  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_REJECT = 2'd3
  } act_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_op;     // latch the input beat
    logic eval;        // register status, slot and cursor; issue read at position
    logic capture_rd;  // take memory read data as the result value
    logic move_rd;     // read the neighbour of the cursor cell
    logic move_wr;     // write it into the cursor cell and step the cursor
    logic write_new;   // write the new value into the slot, count up
    logic len_dec;     // count down after a delete
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    act_t act;   // decoded action of the latched operation
    logic more;  // further cells still to move
    logic ins;   // moves run towards the tail (insert) rather than the head
  } stat_t;

endpackage

@@ sv/ilist_ctrl.sv @@
// Sequencer for the indexed list engine: steps each operation through
// decode, cell moves, final write and result beat. Depends on ilist_pkg.
module ilist_ctrl
  import ilist_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output logic  done,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_EVAL    = 8'b0000_0010,
    S_RD_CAP  = 8'b0000_0100,
    S_LOOP    = 8'b0000_1000,
    S_MOVE_RD = 8'b0001_0000,
    S_MOVE_WR = 8'b0010_0000,
    S_INS_WR  = 8'b0100_0000,
    S_DEL_END = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   fin, fin_next;

  assign busy = (state != S_IDLE) || fin;
  assign done = fin;

  // Next state
  always_comb begin
    state_next = state;
    fin_next   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start && !fin) state_next = S_EVAL;
      end
      S_EVAL: begin
        unique case (stat.act)
          ACT_READ:   state_next = S_RD_CAP;
          ACT_INSERT: state_next = S_LOOP;
          ACT_DELETE: state_next = S_LOOP;
          default: begin
            state_next = S_IDLE;
            fin_next   = 1'b1;
          end
        endcase
      end
      S_RD_CAP: begin
        state_next = S_IDLE;
        fin_next   = 1'b1;
      end
      S_LOOP: begin
        if (stat.more)    state_next = S_MOVE_RD;
        else if (stat.ins) state_next = S_INS_WR;
        else              state_next = S_DEL_END;
      end
      S_MOVE_RD: state_next = S_MOVE_WR;
      S_MOVE_WR: state_next = S_LOOP;
      S_INS_WR: begin
        state_next = S_IDLE;
        fin_next   = 1'b1;
      end
      S_DEL_END: begin
        state_next = S_IDLE;
        fin_next   = 1'b1;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands per state
  always_comb begin
    cmd            = '0;
    cmd.load_op    = (state == S_IDLE) && start && !fin;
    cmd.eval       = (state == S_EVAL);
    cmd.capture_rd = (state == S_RD_CAP);
    cmd.move_rd    = (state == S_MOVE_RD);
    cmd.move_wr    = (state == S_MOVE_WR);
    cmd.write_new  = (state == S_INS_WR);
    cmd.len_dec    = (state == S_DEL_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      fin   <= fin_next;
    end
  end

  // Result beat is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  // An accepted beat always makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted beat did not start an operation");
  // A result beat is only raised from a finishing state
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_EVAL || $past(state) == S_RD_CAP ||
              $past(state) == S_INS_WR || $past(state) == S_DEL_END))
    else $error("result strobe without a finishing state");

endmodule

@@ sv/ilist_dpath.sv @@
// Datapath for the indexed list engine: operand registers, decode, list
// memory, move cursor, count and result registers. Depends on ilist_pkg.
module ilist_dpath
  import ilist_pkg::*;
#(
  parameter int Capacity = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [2:0]         kind,
  input  logic signed [15:0] position,
  input  logic signed [31:0] item_value,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [4:0]         entry_count
);

  localparam int LEN_W  = $clog2(Capacity + 1);
  localparam int ADDR_W = $clog2(Capacity);
  localparam int PW     = (LEN_W > 15) ? LEN_W : 15;
  localparam int EXT_W  = (LEN_W > 5) ? LEN_W : 5;

  // Latched operation
  logic [2:0]        kind_q;
  logic [15:0]       pos_q;
  logic [31:0]       val_q;

  // List state
  logic [31:0]       mem [Capacity];
  logic [31:0]       mem_rdata;
  logic [LEN_W-1:0]  length;
  logic [LEN_W-1:0]  cursor;
  logic [LEN_W-1:0]  slot_q;
  logic              ins_q;
  logic [31:0]       rd_q;
  logic [1:0]        status_q;

  // Decode
  logic              pos_neg;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     len_ext;
  logic              full;
  logic              in_list;
  act_t              act;
  status_t           rej_status;
  logic [LEN_W-1:0]  slot;
  logic [LEN_W-1:0]  cur_dn;
  logic [LEN_W:0]    cur_up;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic [EXT_W-1:0]  len_wide;

  assign pos_neg = pos_q[15];
  assign pos_ext = PW'(pos_q[14:0]);
  assign len_ext = PW'(length);
  assign full    = (length == LEN_W'(Capacity));
  assign in_list = !pos_neg && (pos_ext < len_ext);

  // Map the operation to an action and a target slot
  always_comb begin
    act        = ACT_REJECT;
    rej_status = ST_RANGE;
    slot       = '0;
    case (kind_q)
      KIND_READ: begin
        if (in_list) act = ACT_READ;
      end
      KIND_HEAD: begin
        if (full) rej_status = ST_FULL;
        else act = ACT_INSERT;
      end
      KIND_TAIL: begin
        slot = length;
        if (full) rej_status = ST_FULL;
        else act = ACT_INSERT;
      end
      KIND_AT: begin
        if (pos_neg || pos_ext == '0) begin
          if (full) rej_status = ST_FULL;
          else act = ACT_INSERT;
        end else if (pos_ext > len_ext) begin
          rej_status = ST_RANGE;
        end else begin
          slot = pos_ext[LEN_W-1:0];
          if (full) rej_status = ST_FULL;
          else act = ACT_INSERT;
        end
      end
      KIND_DELETE: begin
        if (in_list) act = ACT_DELETE;
      end
      default: act = ACT_REJECT;
    endcase
  end

  // Cursor neighbours
  assign cur_dn = cursor - LEN_W'(1);
  assign cur_up = {1'b0, cursor} + (LEN_W + 1)'(1);

  assign stat.act  = act;
  assign stat.ins  = ins_q;
  assign stat.more = ins_q ? (cursor > slot_q) : (cur_up < {1'b0, length});

  // Memory port selection
  always_comb begin
    if (cmd.move_rd) begin
      rd_addr = ins_q ? cur_dn[ADDR_W-1:0] : cur_up[ADDR_W-1:0];
    end else begin
      rd_addr = pos_ext[ADDR_W-1:0];
    end
    mem_we  = cmd.move_wr || cmd.write_new;
    wr_addr = cmd.write_new ? slot_q[ADDR_W-1:0] : cursor[ADDR_W-1:0];
    wr_data = cmd.write_new ? val_q : mem_rdata;
  end

  // List memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    mem_rdata <= mem[rd_addr];
  end

  // Operand, cursor and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      kind_q <= kind;
      pos_q  <= position;
      val_q  <= item_value;
    end
    if (cmd.eval) begin
      slot_q   <= slot;
      ins_q    <= (act == ACT_INSERT);
      cursor   <= (act == ACT_INSERT) ? length : pos_ext[LEN_W-1:0];
      status_q <= (act == ACT_REJECT) ? rej_status : ST_DONE;
      rd_q     <= (kind_q == KIND_READ && act == ACT_REJECT) ? 32'hFFFF_FFFF : 32'd0;
    end
    if (cmd.capture_rd) rd_q <= mem_rdata;
    if (cmd.move_wr) cursor <= ins_q ? cur_dn : cur_up[LEN_W-1:0];
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (cmd.write_new) begin
      length <= length + LEN_W'(1);
    end else if (cmd.len_dec) begin
      length <= length - LEN_W'(1);
    end
  end

  assign len_wide    = EXT_W'(length);
  assign read_value  = rd_q;
  assign status      = status_q;
  assign entry_count = len_wide[4:0];

  // The count never passes the number of cells
  a_len_max: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(Capacity))
    else $error("entry count above capacity");
  // No new value is written into a full list
  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.write_new |-> !full)
    else $error("insert committed into a full list");
  // A delete only ends on a non-empty list, and lowers the count by one
  a_del_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.len_dec |=> (length == $past(length) - LEN_W'(1)) && ($past(length) != '0))
    else $error("delete count update wrong");

endmodule

@@ sv/indexed_list_engine.sv @@
// Indexed list engine, top level: ties the sequencer to the datapath.
// Depends on ilist_pkg, ilist_ctrl and ilist_dpath.
//
// An ordered list of up to CAPACITY signed 32-bit values in a one-read,
// one-write memory with a count. Raise start with kind, position and item_value
// while busy is low; the beat is taken at that edge and busy stays high until
// the result. Done marks the result on read_value, status and entry_count and
// is high for exactly one cycle; it cannot be held off, so capture it then. A
// rejected operation goes from evaluation straight to done; a read passes
// evaluation and read capture. Inserts and deletes shift the later entries
// one cell at a time through the memory's one read and one write port, each
// moved entry (up to the count) taking a loop check, a neighbour read and a
// write. The next beat may be accepted in the cycle after done. The memory is
// not cleared at reset; only the count is.
module indexed_list_engine
  import ilist_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic signed [15:0] position,
  input  logic signed [31:0] item_value,
  output logic               done,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [4:0]         entry_count
);

  cmd_t  cmd;
  stat_t stat;

  ilist_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  ilist_dpath #(
    .Capacity (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .kind        (kind),
    .position    (position),
    .item_value  (item_value),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule
